// ----- rtl/sync_xor_frame_extractor_unit_assert.svh -----
// Assertion macros for the sync XOR frame extractor.
// Included by the top level; needs nothing else.
`ifndef SYNC_XOR_FRAME_EXTRACTOR_UNIT_ASSERT_SVH
`define SYNC_XOR_FRAME_EXTRACTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SXFE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SXFE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sxfe_pkg.sv -----
// Package for the sync XOR frame extractor: opcodes, sequencer states, defaults.
// No dependencies.
`default_nettype none

package sxfe_pkg;

   localparam int unsigned DEFAULT_BUFFER_DEPTH = 256;
   localparam logic [7:0]  SYNC_RESET_VALUE     = 8'h55;
   localparam logic [7:0]  MIN_FRAME_LENGTH     = 8'd3;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_PULL = 2'd1,
      OP_END  = 2'd2,
      OP_NOP  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHK_SYNC,
      ST_CHK_LEN,
      ST_SUM,
      ST_EMIT,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/sync_xor_frame_extractor_unit.sv -----
// Sync XOR frame extractor: ring buffer, scanning sequencer and output register.
// Depends on sxfe_pkg and sync_xor_frame_extractor_unit_assert.svh.
//
//   channel  ports                               direction  transfer
//   req      req_valid/ready, opcode, data_byte  in         valid/ready beat
//   rsp      rsp_valid/ready, six result fields  out        valid/ready beat
//   csr      csr_wr_en, csr_wr_data              in         write on enable
//
// Push, end mark and no-op go from idle straight to the response state; a pull that
// emits a byte of a frame already found reads it in the emit state first. A pull
// that scans reads each candidate byte by byte through the single buffer read port,
// which, with registered read data, gives one byte per cycle to the XOR/compare unit.
// Synchronous active-high reset; the buffer needs no clearing pass.
// req_ready is high only in idle; a finished result waits in the output register
// while the next beat is taken, and the sequencer stalls only if it is still full.
`default_nettype none

module sync_xor_frame_extractor_unit #(
   parameter int unsigned BUFFER_DEPTH = sxfe_pkg::DEFAULT_BUFFER_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_opcode,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_out_valid,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_frame_first,
   output logic            rsp_frame_last,
   output logic            rsp_push_refused,
   output logic            rsp_finished,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);
   import sxfe_pkg::*;

   `include "sync_xor_frame_extractor_unit_assert.svh"

   localparam int unsigned AW = $clog2(BUFFER_DEPTH);
   localparam int unsigned HW = $clog2(BUFFER_DEPTH + 1);
   localparam logic [HW-1:0] HELD_FULL = HW'(BUFFER_DEPTH);

   // Ring storage and registered read data
   logic [7:0]    ring [BUFFER_DEPTH];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;

   // Control state
   state_type     state_ff, state_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] scan_ptr_ff, scan_ptr_in;
   logic [HW-1:0] held_ff, held_in;
   logic          emit_active_ff, emit_active_in;
   logic [7:0]    emit_index_ff, emit_index_in;
   logic [7:0]    emit_length_ff, emit_length_in;
   logic          ended_ff, ended_in;
   logic [7:0]    sync_ff;
   logic          rsp_valid_ff, rsp_valid_in;

   // Candidate check working registers
   logic [7:0]    offset_ff, offset_in;
   logic [7:0]    sum_ff, sum_in;

   // Pending result and output register
   logic          res_valid_ff, res_valid_in;
   logic [7:0]    res_byte_ff, res_byte_in;
   logic          res_first_ff, res_first_in;
   logic          res_last_ff, res_last_in;
   logic          res_refused_ff, res_refused_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_first_ff, out_first_in;
   logic          out_last_ff, out_last_in;
   logic          out_refused_ff, out_refused_in;
   logic          out_finished_ff, out_finished_in;

   // Ring address base + offset, wrapped at the buffer depth
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [7:0]    off);
      logic [AW:0] sum;
      sum = {1'b0, base} + (AW+1)'(off);
      if (sum >= (AW+1)'(BUFFER_DEPTH)) begin
         sum = sum - (AW+1)'(BUFFER_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_valid    = out_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_frame_first  = out_first_ff;
   assign rsp_frame_last   = out_last_ff;
   assign rsp_push_refused = out_refused_ff;
   assign rsp_finished     = out_finished_ff;

   // Sequencer: next state, buffer control and result staging
   always_comb begin
      state_in        = state_ff;
      wr_ptr_in       = wr_ptr_ff;
      scan_ptr_in     = scan_ptr_ff;
      held_in         = held_ff;
      emit_active_in  = emit_active_ff;
      emit_index_in   = emit_index_ff;
      emit_length_in  = emit_length_ff;
      ended_in        = ended_ff;
      offset_in       = offset_ff;
      sum_in          = sum_ff;
      res_valid_in    = res_valid_ff;
      res_byte_in     = res_byte_ff;
      res_first_in    = res_first_ff;
      res_last_in     = res_last_ff;
      res_refused_in  = res_refused_ff;
      rsp_valid_in    = rsp_valid_ff;
      out_valid_in    = out_valid_ff;
      out_byte_in     = out_byte_ff;
      out_first_in    = out_first_ff;
      out_last_in     = out_last_ff;
      out_refused_in  = out_refused_ff;
      out_finished_in = out_finished_ff;
      rd_addr         = scan_ptr_ff;
      mem_we          = 1'b0;

      // Release the output register once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_valid_in   = 1'b0;
               res_byte_in    = 8'd0;
               res_first_in   = 1'b0;
               res_last_in    = 1'b0;
               res_refused_in = 1'b0;
               state_in       = ST_RESP;
               case (req_opcode)
                  OP_PUSH: begin
                     if (!ended_ff) begin
                        if (held_ff == HELD_FULL) begin
                           res_refused_in = 1'b1;
                        end else begin
                           mem_we    = 1'b1;
                           wr_ptr_in = wrap_add(wr_ptr_ff, 8'd1);
                           held_in   = held_ff + HW'(1);
                        end
                     end
                  end
                  OP_PULL: begin
                     if (emit_active_ff) begin
                        rd_addr  = wrap_add(scan_ptr_ff, emit_index_ff);
                        state_in = ST_EMIT;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_END: begin
                     ended_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // Fetch the oldest held byte, or stop when nothing is held
            if (held_ff == HW'(0)) begin
               state_in = ST_RESP;
            end else begin
               rd_addr  = scan_ptr_ff;
               state_in = ST_CHK_SYNC;
            end
         end

         ST_CHK_SYNC: begin
            if (rd_data_ff != sync_ff) begin
               scan_ptr_in = wrap_add(scan_ptr_ff, 8'd1);
               held_in     = held_ff - HW'(1);
               state_in    = ST_SCAN;
            end else if (held_ff < HW'(2)) begin
               if (ended_ff) begin
                  scan_ptr_in = wrap_add(scan_ptr_ff, 8'd1);
                  held_in     = held_ff - HW'(1);
                  state_in    = ST_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               rd_addr  = wrap_add(scan_ptr_ff, 8'd1);
               state_in = ST_CHK_LEN;
            end
         end

         ST_CHK_LEN: begin
            // Check length, then start the checksum run at the first payload byte
            if (rd_data_ff < MIN_FRAME_LENGTH) begin
               scan_ptr_in = wrap_add(scan_ptr_ff, 8'd1);
               held_in     = held_ff - HW'(1);
               state_in    = ST_SCAN;
            end else if (held_ff < HW'(rd_data_ff)) begin
               if (ended_ff) begin
                  scan_ptr_in = wrap_add(scan_ptr_ff, 8'd1);
                  held_in     = held_ff - HW'(1);
                  state_in    = ST_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               sum_in         = sync_ff ^ rd_data_ff;
               emit_length_in = rd_data_ff;
               offset_in      = 8'd2;
               rd_addr        = wrap_add(scan_ptr_ff, 8'd2);
               state_in       = ST_SUM;
            end
         end

         ST_SUM: begin
            // Fold payload bytes, compare at the checksum position
            if (offset_ff == emit_length_ff - 8'd1) begin
               if (sum_ff == rd_data_ff) begin
                  emit_active_in = 1'b1;
                  emit_index_in  = 8'd0;
                  rd_addr        = scan_ptr_ff;
                  state_in       = ST_EMIT;
               end else begin
                  scan_ptr_in = wrap_add(scan_ptr_ff, 8'd1);
                  held_in     = held_ff - HW'(1);
                  state_in    = ST_SCAN;
               end
            end else begin
               sum_in    = sum_ff ^ rd_data_ff;
               offset_in = offset_ff + 8'd1;
               rd_addr   = wrap_add(scan_ptr_ff, offset_ff + 8'd1);
            end
         end

         ST_EMIT: begin
            res_valid_in = 1'b1;
            res_byte_in  = rd_data_ff;
            res_first_in = (emit_index_ff == 8'd0);
            res_last_in  = (emit_index_ff + 8'd1 == emit_length_ff);
            if (emit_index_ff + 8'd1 == emit_length_ff) begin
               // Frame done: drop only its sync byte so overlaps are still found
               emit_active_in = 1'b0;
               emit_index_in  = 8'd0;
               scan_ptr_in    = wrap_add(scan_ptr_ff, 8'd1);
               held_in        = held_ff - HW'(1);
            end else begin
               emit_index_in = emit_index_ff + 8'd1;
            end
            state_in = ST_RESP;
         end

         ST_RESP: begin
            // Load the output register when it is free or being taken
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               out_valid_in    = res_valid_ff;
               out_byte_in     = res_byte_ff;
               out_first_in    = res_first_ff;
               out_last_in     = res_last_ff;
               out_refused_in  = res_refused_ff;
               out_finished_in = ended_ff && !emit_active_ff && (held_ff == HW'(0));
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Ring write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring[wr_ptr_ff] <= req_data_byte;
      end
      rd_data_ff <= ring[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         wr_ptr_ff      <= '0;
         scan_ptr_ff    <= '0;
         held_ff        <= '0;
         emit_active_ff <= 1'b0;
         emit_index_ff  <= 8'd0;
         emit_length_ff <= 8'd0;
         ended_ff       <= 1'b0;
         sync_ff        <= SYNC_RESET_VALUE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         wr_ptr_ff      <= wr_ptr_in;
         scan_ptr_ff    <= scan_ptr_in;
         held_ff        <= held_in;
         emit_active_ff <= emit_active_in;
         emit_index_ff  <= emit_index_in;
         emit_length_ff <= emit_length_in;
         ended_ff       <= ended_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            sync_ff <= csr_wr_data;
         end
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      offset_ff       <= offset_in;
      sum_ff          <= sum_in;
      res_valid_ff    <= res_valid_in;
      res_byte_ff     <= res_byte_in;
      res_first_ff    <= res_first_in;
      res_last_ff     <= res_last_in;
      res_refused_ff  <= res_refused_in;
      out_valid_ff    <= out_valid_in;
      out_byte_ff     <= out_byte_in;
      out_first_ff    <= out_first_in;
      out_last_ff     <= out_last_in;
      out_refused_ff  <= out_refused_in;
      out_finished_ff <= out_finished_in;
   end

   // Checks
   `SXFE_ASSERT_IMP(a_held_bound, clock, reset, 1'b1, held_ff <= HELD_FULL,
                    "held count over depth")
   `SXFE_ASSERT_IMP(a_emit_held, clock, reset, emit_active_ff,
                    (emit_length_ff >= MIN_FRAME_LENGTH) && (emit_index_ff < emit_length_ff)
                    && (held_ff >= HW'(emit_length_ff)),
                    "frame being emitted not fully held")
   `SXFE_ASSERT_NXT(a_busy_after_beat, clock, reset, req_valid && req_ready, !req_ready,
                    "beat taken while busy")

endmodule

`default_nettype wire
